>>> rtl/core/brltc_pkg.sv
// Shared constants, state and result types for the button, relay and LED tick controller.
package brltc_pkg;

    // Ticks in one second, and the width of the tick phase counter
    localparam int TICKS_PER_SECOND = 10;
    localparam int PHASE_W          = $clog2(TICKS_PER_SECOND);
    localparam int SLOT_UNIT        = TICKS_PER_SECOND / 10;

    // Phase slots for update countdown, save/restart and wifi action
    localparam logic [PHASE_W-1:0] SLOT_UPDATE = PHASE_W'(SLOT_UNIT * 2);
    localparam logic [PHASE_W-1:0] SLOT_SAVE   = PHASE_W'(SLOT_UNIT * 4);
    localparam logic [PHASE_W-1:0] SLOT_WIFI   = PHASE_W'(SLOT_UNIT * 6);
    localparam logic [PHASE_W:0]   PHASE_WRAP  = (PHASE_W + 1)'(TICKS_PER_SECOND);

    // Counter loads
    localparam logic [2:0]  HOLD_RESTART_DELAY = 3'd4;
    localparam logic [15:0] SMART_BLINKS       = 16'd1000;
    localparam logic [15:0] RESET_BLINKS       = 16'd3;
    localparam logic [15:0] PRESS_BLINKS       = 16'd1;
    localparam logic [15:0] HOLD_BLINKS        = 16'd2;
    localparam logic [7:0]  SMART_PRESSES      = 8'd3;
    localparam logic [7:0]  UPDATE_PRESSES     = 8'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRESS_WINDOW = 2'd0;
    localparam logic [1:0] CFG_LONG_HOLD    = 2'd1;
    localparam logic [1:0] CFG_POWER_START  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] PRESS_WINDOW_RST = 8'd10;
    localparam logic [7:0] LONG_HOLD_RST    = 8'd40;

    // Wifi action codes
    localparam logic [1:0] WIFI_NONE   = 2'd0;
    localparam logic [1:0] WIFI_STATUS = 2'd1;
    localparam logic [1:0] WIFI_SMART  = 2'd2;

    typedef struct packed {
        logic [PHASE_W-1:0] tick_phase;
        logic               last_button;
        logic [7:0]         hold_count;
        logic [7:0]         press_window;
        logic [7:0]         press_count;
        logic [15:0]        blink_count;
        logic               led_state;
        logic               led_pin;
        logic               relay_state;
        logic [1:0]         update_countdown;
        logic [2:0]         restart_countdown;
        logic               smartconfig_pending;
        logic               halted;
    } t_state;

    typedef struct packed {
        logic       relay_on;
        logic       led_level;
        logic       power_report;
        logic       factory_reset;
        logic       save_settings;
        logic       restart_now;
        logic       update_start;
        logic [1:0] wifi_action;
        logic       second_pulse;
    } t_result;

    typedef struct packed {
        logic [7:0] press_window_ticks;
        logic [7:0] long_hold_ticks;
    } t_cfg;

endpackage

>>> rtl/core/brltc_step.sv
// Next-state and result logic for one tick of the controller.
module brltc_step
    import brltc_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  logic    i_button_level,
    output t_state  o_state,
    output t_result o_result
);

    t_state         s;
    t_result        r;
    logic [PHASE_W:0] phase_inc;

    always_comb begin
        s         = i_state;
        r         = '0;
        phase_inc = '0;

        if (!i_state.halted) begin
            // Advance the phase counter and wrap once per second
            phase_inc = {1'b0, i_state.tick_phase} + 1'b1;
            if (phase_inc >= PHASE_WRAP) begin
                s.tick_phase   = '0;
                r.second_pulse = 1'b1;
            end else begin
                s.tick_phase = phase_inc[PHASE_W-1:0];
            end

            // Open or extend the multi-press window on a falling edge
            if (!i_button_level && i_state.last_button) begin
                if (i_state.press_window == 8'd0) begin
                    s.press_count  = 8'd1;
                    s.relay_state  = ~i_state.relay_state;
                    r.power_report = 1'b1;
                end else begin
                    s.press_count = i_state.press_count + 8'd1;
                end
                s.blink_count  = PRESS_BLINKS;
                s.press_window = i_cfg.press_window_ticks;
            end
            s.last_button = i_button_level;

            // Count held ticks and fire factory reset at the limit
            if (i_button_level) begin
                s.hold_count = 8'd0;
            end else begin
                s.hold_count = i_state.hold_count + 8'd1;
                if (s.hold_count == i_cfg.long_hold_ticks) begin
                    r.factory_reset     = 1'b1;
                    s.press_count       = 8'd0;
                    s.restart_countdown = HOLD_RESTART_DELAY;
                    s.blink_count       = HOLD_BLINKS;
                end
            end

            // Run the window down, or act on the press count when it closes
            if (s.press_window != 8'd0) begin
                s.press_window = s.press_window - 8'd1;
            end else begin
                if (s.press_count == SMART_PRESSES) begin
                    s.smartconfig_pending = 1'b1;
                    s.blink_count         = SMART_BLINKS;
                end else if (s.press_count == UPDATE_PRESSES) begin
                    s.update_countdown = 2'd1;
                    s.led_pin          = 1'b0;
                end
                s.press_count = 8'd0;
            end

            // Blink the LED on odd phases
            if (s.blink_count != 16'd0 && s.tick_phase[0]) begin
                s.led_state = ~i_state.led_state;
                s.led_pin   = s.led_state;
                if (s.led_state) begin
                    s.blink_count = s.blink_count - 16'd1;
                end
            end

            // Phase slot actions
            if (s.tick_phase == SLOT_UPDATE) begin
                if (s.update_countdown != 2'd0) begin
                    s.update_countdown = s.update_countdown - 2'd1;
                    if (s.update_countdown == 2'd0) begin
                        r.update_start = 1'b1;
                        s.halted       = 1'b1;
                    end
                end
            end else if (s.tick_phase == SLOT_SAVE) begin
                r.save_settings = 1'b1;
                if (s.restart_countdown != 3'd0) begin
                    s.restart_countdown = s.restart_countdown - 3'd1;
                    if (s.restart_countdown == 3'd0) begin
                        r.restart_now = 1'b1;
                    end
                end
            end else if (s.tick_phase == SLOT_WIFI) begin
                r.wifi_action         = s.smartconfig_pending ? WIFI_SMART : WIFI_STATUS;
                s.smartconfig_pending = 1'b0;
            end
        end

        r.relay_on  = s.relay_state;
        r.led_level = s.led_pin;
    end

    assign o_state  = s;
    assign o_result = r;

endmodule

>>> rtl/core/button_relay_led_tick_controller_unit.sv
// Top level of the button, relay and LED tick controller.
//
// Each input request is one 100 ms tick with the sampled button level
// (0 pressed). The block answers every tick with exactly one result request:
// relay drive, LED pin level, event pulses and the wifi action code.
// Channels are valid/ready. A tick is accepted whenever the result register
// is empty or being drained in the same cycle and no configuration write is
// offered; with the receiver ready one tick is accepted every cycle, and its
// result appears in the next cycle. If the receiver stalls, the result holds
// and input ready drops until it is taken; no result is lost or repeated.
// Configuration writes (index 0 window ticks, 1 long-hold ticks, 2 power at
// start) are always accepted; writing index 2 also loads the relay state.
// A tick waits while a configuration write is offered.
// Unknown indexes are ignored. Write configuration only while idle.
// Reset (synchronous, active low) restores the default registers, phase 0,
// blink count 3, LED off and relay off, and empties the result register.
// After an update start pulse the block halts until the next reset: results
// keep LED and relay levels (unless index 2 is written) with all pulses low.
module button_relay_led_tick_controller_unit
    import brltc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // tick input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_button_level,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_relay_on,
    output logic       o_led_level,
    output logic       o_power_report,
    output logic       o_factory_reset,
    output logic       o_save_settings,
    output logic       o_restart_now,
    output logic       o_update_start,
    output logic [1:0] o_wifi_action,
    output logic       o_second_pulse
);

    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_take;
    logic    cfg_take;

    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid;
    assign o_in_ready  = (!r_out_valid || i_out_ready) && !i_cfg_valid;
    assign in_take     = i_in_valid && o_in_ready;

    brltc_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_button_level (i_button_level),
        .o_state        (n_state),
        .o_result       (n_result)
    );

    // Hold configuration and controller state; advance on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_window_ticks    <= PRESS_WINDOW_RST;
            r_cfg.long_hold_ticks       <= LONG_HOLD_RST;
            r_state.tick_phase          <= '0;
            r_state.last_button         <= 1'b1;
            r_state.hold_count          <= '0;
            r_state.press_window        <= '0;
            r_state.press_count         <= '0;
            r_state.blink_count         <= RESET_BLINKS;
            r_state.led_state           <= 1'b1;
            r_state.led_pin             <= 1'b1;
            r_state.relay_state         <= 1'b0;
            r_state.update_countdown    <= '0;
            r_state.restart_countdown   <= '0;
            r_state.smartconfig_pending <= 1'b0;
            r_state.halted              <= 1'b0;
        end else if (cfg_take) begin
            unique case (i_cfg_index)
                CFG_PRESS_WINDOW: r_cfg.press_window_ticks <= i_cfg_data;
                CFG_LONG_HOLD:    r_cfg.long_hold_ticks    <= i_cfg_data;
                CFG_POWER_START: begin
                    r_state.relay_state <= i_cfg_data[0];
                end
                default: ;
            endcase
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // Result register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_relay_on      = r_result.relay_on;
    assign o_led_level     = r_result.led_level;
    assign o_power_report  = r_result.power_report;
    assign o_factory_reset = r_result.factory_reset;
    assign o_save_settings = r_result.save_settings;
    assign o_restart_now   = r_result.restart_now;
    assign o_update_start  = r_result.update_start;
    assign o_wifi_action   = r_result.wifi_action;
    assign o_second_pulse  = r_result.second_pulse;

endmodule

>>> verif/brltc_tick_checker.sv
// Checker that predicts every tick result of the button, relay and LED controller and compares it.
`timescale 1ns / 1ps
module brltc_tick_checker
    import brltc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_button_level,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_result    i_result,
    output int         o_fail_count,
    output int         o_pending
);

    // Register copies
    logic [7:0]         window_ticks;
    logic [7:0]         hold_ticks;

    // Controller state copy
    logic [PHASE_W-1:0] phase;
    logic               prev_key;
    logic [7:0]         held;
    logic [7:0]         window_left;
    logic [7:0]         presses;
    logic [15:0]        blinks_left;
    logic               led_toggle;
    logic               led_pin;
    logic               relay;
    logic [1:0]         update_wait;
    logic [2:0]         restart_wait;
    logic               smart_req;
    logic               frozen;

    t_result            results_due[$];
    int                 fails;

    // Advance the state copy by one tick and return the result it gives
    function automatic t_result next_tick(input logic key);
        t_result r;
        r = '0;
        r.wifi_action = WIFI_NONE;
        if (!frozen) begin
            // advance the phase, wrap once a second
            if (phase == PHASE_W'(TICKS_PER_SECOND - 1)) begin
                phase = '0;
                r.second_pulse = 1'b1;
            end else begin
                phase = phase + 1'b1;
            end

            // falling edge: open or extend the multi-press window
            if (!key && prev_key) begin
                if (window_left == 8'd0) begin
                    presses = 8'd1;
                    relay = ~relay;
                    r.power_report = 1'b1;
                end else begin
                    presses = presses + 8'd1;
                end
                blinks_left = PRESS_BLINKS;
                window_left = window_ticks;
            end
            prev_key = key;

            // count held ticks, long hold arms the restart
            if (key) begin
                held = 8'd0;
            end else begin
                held = held + 8'd1;
                if (held == hold_ticks) begin
                    r.factory_reset = 1'b1;
                    presses = 8'd0;
                    restart_wait = HOLD_RESTART_DELAY;
                    blinks_left = HOLD_BLINKS;
                end
            end

            // close the window and act on the press count
            if (window_left != 8'd0) begin
                window_left = window_left - 8'd1;
            end else begin
                if (presses == SMART_PRESSES) begin
                    smart_req = 1'b1;
                    blinks_left = SMART_BLINKS;
                end else if (presses == UPDATE_PRESSES) begin
                    update_wait = 2'd1;
                    led_pin = 1'b0;
                end
                presses = 8'd0;
            end

            // blink on odd phases
            if (blinks_left != 16'd0 && phase[0]) begin
                led_toggle = ~led_toggle;
                led_pin = led_toggle;
                if (led_toggle)
                    blinks_left = blinks_left - 16'd1;
            end

            // phase slots
            if (phase == SLOT_UPDATE) begin
                if (update_wait != 2'd0) begin
                    update_wait = update_wait - 2'd1;
                    if (update_wait == 2'd0) begin
                        r.update_start = 1'b1;
                        frozen = 1'b1;
                    end
                end
            end else if (phase == SLOT_SAVE) begin
                r.save_settings = 1'b1;
                if (restart_wait != 3'd0) begin
                    restart_wait = restart_wait - 3'd1;
                    if (restart_wait == 3'd0)
                        r.restart_now = 1'b1;
                end
            end else if (phase == SLOT_WIFI) begin
                r.wifi_action = smart_req ? WIFI_SMART : WIFI_STATUS;
                smart_req = 1'b0;
            end
        end
        r.relay_on = relay;
        r.led_level = led_pin;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [1:0] want,
                                        input logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            // load reset state
            window_ticks = PRESS_WINDOW_RST;
            hold_ticks = LONG_HOLD_RST;
            phase = '0;
            prev_key = 1'b1;
            held = 8'd0;
            window_left = 8'd0;
            presses = 8'd0;
            blinks_left = RESET_BLINKS;
            led_toggle = 1'b1;
            led_pin = 1'b1;
            relay = 1'b0;
            update_wait = 2'd0;
            restart_wait = 3'd0;
            smart_req = 1'b0;
            frozen = 1'b0;
            results_due.delete();
        end else begin
            // apply register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRESS_WINDOW: window_ticks = i_cfg_data;
                    CFG_LONG_HOLD:    hold_ticks = i_cfg_data;
                    CFG_POWER_START:  relay = i_cfg_data[0];
                    default: ;
                endcase
            end

            // compare a taken result with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with no tick waiting, expected none actual %h",
                             $time, i_result);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    check_field("relay_on", want.relay_on, i_result.relay_on);
                    check_field("led_level", want.led_level, i_result.led_level);
                    check_field("power_report", want.power_report, i_result.power_report);
                    check_field("factory_reset", want.factory_reset, i_result.factory_reset);
                    check_field("save_settings", want.save_settings, i_result.save_settings);
                    check_field("restart_now", want.restart_now, i_result.restart_now);
                    check_field("update_start", want.update_start, i_result.update_start);
                    check_field("wifi_action", want.wifi_action, i_result.wifi_action);
                    check_field("second_pulse", want.second_pulse, i_result.second_pulse);
                end
            end

            // predict the result of an accepted tick
            if (i_in_valid && i_in_ready)
                results_due.push_back(next_tick(i_button_level));
        end
        o_fail_count <= fails;
        o_pending <= results_due.size();
    end

endmodule

>>> verif/button_relay_led_tick_controller_unit_tb.sv
// Testbench top: drives ticks, register writes and result stalls, and gives the verdict.
`timescale 1ns / 1ps
module button_relay_led_tick_controller_unit_tb
    import brltc_pkg::*;
();

    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int         QUIET_LIMIT = 5000;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [1:0] i_cfg_index    = CFG_PRESS_WINDOW;
    logic [7:0] i_cfg_data     = 8'd0;
    logic       i_in_valid     = 1'b0;
    logic       i_button_level = 1'b1;
    logic       i_out_ready    = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_relay_on;
    logic       o_led_level;
    logic       o_power_report;
    logic       o_factory_reset;
    logic       o_save_settings;
    logic       o_restart_now;
    logic       o_update_start;
    logic [1:0] o_wifi_action;
    logic       o_second_pulse;

    int         fail_count;
    int         pending;
    int         send_gap     = 0;
    int         stall_pct    = 0;
    int         ticks_sent   = 0;
    int         quiet_cycles = 0;

    // Window and setting tracking: keeps random presses from arming an update, sizes holds
    logic [7:0] window_cfg_now = PRESS_WINDOW_RST;
    logic [7:0] hold_cfg_now   = LONG_HOLD_RST;
    logic [7:0] win_left       = 8'd0;
    logic [7:0] presses_seen   = 8'd0;
    logic       last_key       = 1'b1;

    button_relay_led_tick_controller_unit dut (.*);

    brltc_tick_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_button_level (i_button_level),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result       ({o_relay_on, o_led_level, o_power_report, o_factory_reset,
                          o_save_settings, o_restart_now, o_update_start, o_wifi_action,
                          o_second_pulse}),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Stall the result receiver at random
    always @(posedge i_clk) begin
        i_out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    // End the run when no request moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_gap = 0;  stall_pct = 0;  end
            1: begin send_gap = 75; stall_pct = 0;  end
            2: begin send_gap = 0;  stall_pct = 75; end
            default: begin send_gap = 15; stall_pct = 15; end
        endcase
    endtask

    // Send one tick request; free_press lets a fourth press of a window through
    task automatic send_tick(input logic level, input bit free_press);
        logic key;
        key = level;
        // drop a press that would arm an update
        if (!free_press && !key && last_key && win_left != 8'd0 &&
            presses_seen == SMART_PRESSES)
            key = 1'b1;
        if (!key && last_key) begin
            presses_seen = (win_left == 8'd0) ? 8'd1 : presses_seen + 8'd1;
            win_left = window_cfg_now;
        end
        last_key = key;
        if (win_left != 8'd0)
            win_left = win_left - 8'd1;
        else
            presses_seen = 8'd0;

        // idle the sender
        if (send_gap != 0 && $urandom_range(99) < send_gap) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap);
        end
        i_in_valid <= 1'b1;
        i_button_level <= key;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // Hold the input and wait until every result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [7:0] win, input logic [7:0] hold,
                               input logic [7:0] power_data);
        settle();
        write_reg(CFG_PRESS_WINDOW, win);
        write_reg(CFG_LONG_HOLD, hold);
        write_reg(CFG_POWER_START, power_data);
        window_cfg_now = win;
        hold_cfg_now = hold;
    endtask

    task automatic quiet_until_closed();
        while (win_left != 8'd0)
            send_tick(1'b1, 1'b0);
    endtask

    // Rapid one-tick presses, counted exactly as given
    task automatic press_run(input int n);
        send_tick(1'b1, 1'b1);
        repeat (n) begin
            send_tick(1'b0, 1'b1);
            send_tick(1'b1, 1'b1);
        end
    endtask

    task automatic hold_run(input int n);
        while (win_left != 8'd0 && presses_seen == SMART_PRESSES)
            send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        repeat (n) send_tick(1'b0, 1'b0);
    endtask

    // Random gestures: single presses, short bursts, long holds, noise and quiet stretches
    task automatic run_random(input int n);
        int stop;
        int len;
        stop = ticks_sent + n;
        while (ticks_sent < stop) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    repeat ($urandom_range(1, 4)) send_tick(1'b1, 1'b0);
                    repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
                end
                3, 4: begin
                    repeat ($urandom_range(2, 3)) begin
                        send_tick(1'b1, 1'b0);
                        send_tick(1'b0, 1'b0);
                    end
                end
                5: begin
                    len = (hold_cfg_now == 8'd0) ? 256 : int'(hold_cfg_now);
                    len = len + $urandom_range(0, 3);
                    if (len > 60)
                        len = $urandom_range(5, 60);
                    hold_run(len);
                end
                6, 7: repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)), 1'b0);
                8: repeat ($urandom_range(5, 30)) send_tick(1'b1, 1'b0);
                default: begin
                    // five or more presses pass through four without arming an update
                    if (win_left == 8'd0 && window_cfg_now >= 8'd4)
                        press_run($urandom_range(5, 8));
                    else
                        repeat (3) send_tick(1'b1, 1'b0);
                end
            endcase
        end
    endtask

    initial begin
        // reset
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single press toggles the relay, triple press asks for smart config
        set_idle(0);
        repeat (2) send_tick(1'b1, 1'b0);
        repeat (2) send_tick(1'b0, 1'b0);
        repeat (10) send_tick(1'b1, 1'b0);
        repeat (3) begin
            send_tick(1'b0, 1'b0);
            send_tick(1'b1, 1'b0);
        end
        repeat (10) send_tick(1'b1, 1'b0);

        // default-like settings with the relay loaded on
        set_idle(0);
        reconfigure(8'd10, 8'd40, 8'h01);
        run_random(100);

        // zero window, shortest hold
        set_idle(1);
        reconfigure(8'd0, 8'd1, 8'hFE);
        run_random(100);

        // longest window and hold
        set_idle(2);
        reconfigure(8'd255, 8'd255, 8'h01);
        hold_run(300);
        run_random(60);

        // zero hold fires only when the held count wraps
        set_idle(3);
        reconfigure(8'd1, 8'd0, 8'($urandom));
        hold_run(270);
        run_random(60);

        // press count wraps to three
        set_idle(0);
        reconfigure(8'd4, 8'd2, 8'h80);
        quiet_until_closed();
        press_run(259);
        run_random(60);

        // random settings, unknown register index
        set_idle(1);
        reconfigure(8'($urandom_range(4, 20)), 8'($urandom_range(2, 60)), 8'($urandom));
        write_reg(CFG_SPARE, 8'($urandom));
        run_random(60);

        set_idle(2);
        reconfigure(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 8'($urandom));
        run_random(80);

        // four presses arm the update, then the block halts
        set_idle(3);
        reconfigure(8'd10, 8'd40, 8'h7F);
        quiet_until_closed();
        press_run(4);
        repeat (60) send_tick(1'($urandom_range(1)), 1'b1);

        // drain and give the verdict
        settle();
        repeat (3) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
